// ----- design/sma_pkg.sv -----
// shared constants and types for the moving-average block
// used by sma_div and simple_moving_average; depends on nothing
`timescale 1ns / 1ps

package sma_pkg;

    localparam int MAX_PERIOD = 64;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 22;
    localparam int FRAC_W     = 8;
    localparam int MEAN_W     = 24;
    localparam int PERIOD_W   = 7;
    localparam int POS_W      = $clog2(MAX_PERIOD);
    localparam int CNT_W      = $clog2(MAX_PERIOD + 1);
    localparam int DIVD_W     = SUM_W + FRAC_W;
    localparam int STEP_W     = $clog2(DIVD_W);

    // request from the sequencer to the divider
    typedef struct packed {
        logic              start;
        logic              negative;
        logic [DIVD_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } div_req_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic                     busy;
        logic signed [MEAN_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- design/sma_div.sv -----
// serial restoring divider, one quotient bit a cycle, signed result
// depends on sma_pkg
`timescale 1ns / 1ps

module sma_div
    import sma_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIVD_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  divisor_reg, divisor_next;
    logic              neg_reg, neg_next;
    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;

    assign shifted = {rem_reg, quot_reg[DIVD_W-1]};
    assign diff    = shifted - {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        step_next    = step_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            step_next    = STEP_W'(DIVD_W - 1);
            quot_next    = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
            neg_next     = req.negative;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the top bit of diff is spare
            if (shifted >= {1'b0, divisor_reg})
            begin
                rem_next  = diff[CNT_W-1:0];
                quot_next = {quot_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[CNT_W-1:0];
                quot_next = {quot_reg[DIVD_W-2:0], 1'b0};
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
    end

    // magnitude quotient always fits the mean width; sign restores truncation toward zero
    assign rsp.busy     = busy_reg;
    assign rsp.quotient = neg_reg ? -$signed(quot_reg[MEAN_W-1:0])
                                  : $signed(quot_reg[MEAN_W-1:0]);

endmodule

// ----- design/simple_moving_average.sv -----
// top level of the simple moving average: window store, running sum, sequencer
// depends on sma_pkg and sma_div
`timescale 1ns / 1ps

// Simple moving average over the last period signed 16-bit samples. Each sample
// request gives exactly one result: the mean of the window in signed fixed point
// with 8 fraction bits, truncated toward zero, and the number of samples that it
// covers (it counts up while the window fills, then stays at the period). The
// period register takes 1..64 (0 acts as 1, larger values act as 64); writing it
// restarts the window, and it must only be written while the block is idle. A
// sample passes in order: reading the oldest sample from the window memory,
// updating the running sum and starting the divide, the bit-serial divider (one
// quotient bit per cycle over the 22-bit sum scaled by 256) and loading the
// output register, which waits while a held result is stalled. No new sample is
// accepted before then; the output register holds a finished result while the next
// sample is accepted and worked on. The window memory needs no clearing after reset.
module simple_moving_average
    import sma_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // period register write
    input  logic                       period_wen,
    input  logic [PERIOD_W-1:0]        period_wdata,
    // sample requests
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    // result requests
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [MEAN_W-1:0]   mean,
    output logic [PERIOD_W-1:0]        samples_in_window
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [PERIOD_W-1:0]        period_reg;
    logic [POS_W-1:0]           write_position_reg, write_position_next;
    logic [CNT_W-1:0]           fill_count_reg, fill_count_next;
    logic signed [SUM_W-1:0]    running_sum_reg, running_sum_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [POS_W-1:0]           pos_reg, pos_now;
    logic                       full_reg;
    logic signed [SAMPLE_W-1:0] window_mem [MAX_PERIOD];
    logic signed [SAMPLE_W-1:0] old_sample_reg;

    logic                       result_valid_reg, result_valid_next;
    logic signed [MEAN_W-1:0]   mean_reg;
    logic [PERIOD_W-1:0]        count_out_reg;

    logic [CNT_W-1:0]           eff_period;
    logic [POS_W:0]             pos_inc;
    logic                       accept;
    logic                       mem_we;
    logic                       load_out;
    logic [SUM_W-1:0]           sum_mag;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    // period 0 behaves as 1, anything past the store depth as the depth
    always_comb
    begin
        if (period_reg == '0)
        begin
            eff_period = CNT_W'(1);
        end
        else if ({1'b0, period_reg} > (PERIOD_W + 1)'(MAX_PERIOD))
        begin
            eff_period = CNT_W'(MAX_PERIOD);
        end
        else
        begin
            eff_period = CNT_W'(period_reg);
        end
    end

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != S_IDLE);

    // slot for the incoming sample, wrapped in case the period shrank
    assign pos_now = (CNT_W'(write_position_reg) >= eff_period) ? '0 : write_position_reg;

    assign mem_we  = (state_reg == S_READ);
    assign pos_inc = {1'b0, pos_reg} + 1'b1;

    // window update: a period write restarts the window; else drop the oldest sample once full, add the new one
    always_comb
    begin
        write_position_next = write_position_reg;
        fill_count_next     = fill_count_reg;
        running_sum_next    = running_sum_reg;
        if (period_wen)
        begin
            write_position_next = '0;
            fill_count_next     = '0;
            running_sum_next    = '0;
        end
        else if (mem_we)
        begin
            running_sum_next = running_sum_reg
                             - (full_reg ? SUM_W'(old_sample_reg) : '0)
                             + SUM_W'(sample_reg);
            if (!full_reg)
            begin
                fill_count_next = fill_count_reg + 1'b1;
            end
            if (CNT_W'(pos_inc) >= eff_period)
            begin
                write_position_next = '0;
            end
            else
            begin
                write_position_next = pos_inc[POS_W-1:0];
            end
        end
    end

    // divide request: |sum| * 256 over the updated fill count
    assign sum_mag          = running_sum_next[SUM_W-1] ? 
                              SUM_W'(-running_sum_next) : SUM_W'(running_sum_next);
    assign div_req.start    = mem_we;
    assign div_req.negative = running_sum_next[SUM_W-1];
    assign div_req.dividend = {sum_mag, {FRAC_W{1'b0}}};
    assign div_req.divisor  = fill_count_next;

    sma_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // result goes out once the divider is done and the output register is free
    assign load_out = (state_reg == S_DIV) && !div_rsp.busy
                   && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load_out)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            period_reg         <= PERIOD_W'(8);
            write_position_reg <= '0;
            fill_count_reg     <= '0;
            running_sum_reg    <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            write_position_reg <= write_position_next;
            fill_count_reg     <= fill_count_next;
            running_sum_reg    <= running_sum_next;
            result_valid_reg   <= result_valid_next;
            if (period_wen)
            begin
                period_reg <= period_wdata;
            end
        end
    end

    // captured request data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            pos_reg    <= pos_now;
            full_reg   <= (fill_count_reg >= eff_period);
        end
        if (load_out)
        begin
            mean_reg      <= div_rsp.quotient;
            count_out_reg <= PERIOD_W'(fill_count_reg);
        end
    end

    // window memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            window_mem[pos_reg] <= sample_reg;
        end
        old_sample_reg <= window_mem[pos_now];
    end

    assign result_valid      = result_valid_reg;
    assign mean              = mean_reg;
    assign samples_in_window = count_out_reg;

    // the fill count never passes the active period
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= eff_period)
        else $error("fill count beyond period");

    // the write slot stays inside the active window
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(write_position_reg) < eff_period)
        else $error("write position outside window");

    // a new result only appears after the divider has finished
    a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> result_valid_reg && (state_reg == S_IDLE))
        else $error("result load out of sequence");

    // the divider is running whenever the sequencer waits on it right after starting
    a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> div_rsp.busy)
        else $error("divider did not start");

endmodule

// ----- test/simple_moving_average_tb.sv -----
// self-checking testbench for simple_moving_average: scoreboard class plus driver tasks
// depends on sma_pkg and the simple_moving_average rtl
`timescale 1ns / 1ps

module simple_moving_average_tb;
    import sma_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int PERIOD_RESET    = 8;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int DIRECTED_ITEMS  = 13;
    localparam int DIRECTED_AT_RST = 10;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 40;
    localparam int LONG_HOLD       = 600;
    localparam int STREAK_LEN      = 70;
    localparam int REPORT_LIMIT    = 10;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // one expected result
    typedef struct {
        logic signed [MEAN_W-1:0] mean;
        logic [PERIOD_W-1:0]      count;
    } window_mean_t;

    // own copy of the window, running sum and period, plus the queue of expected means
    class window_scoreboard;
        logic signed [SAMPLE_W-1:0] window [MAX_PERIOD];
        int                         period_eff;
        int                         wr_pos;
        int                         fill;
        longint                     sum;
        window_mean_t               pending [$];
        int                         errors;

        function new();
            errors = 0;
            set_period(PERIOD_W'(PERIOD_RESET));
        endfunction

        // zero acts as one, anything above the store depth acts as the depth
        function void set_period(logic [PERIOD_W-1:0] p);
            if (p == 0)
                period_eff = 1;
            else if (p > MAX_PERIOD)
                period_eff = MAX_PERIOD;
            else
                period_eff = p;
            wr_pos = 0;
            fill   = 0;
            sum    = 0;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] s);
            window_mean_t e;
            if (wr_pos >= period_eff)
                wr_pos = 0;
            if (fill < period_eff)
                fill++;
            else
                sum -= window[wr_pos];
            sum += s;
            window[wr_pos] = s;
            wr_pos = (wr_pos + 1 >= period_eff) ? 0 : wr_pos + 1;
            // signed division truncates toward zero
            e.mean  = MEAN_W'((sum <<< FRAC_W) / longint'(fill));
            e.count = PERIOD_W'(fill);
            pending.push_back(e);
        endfunction

        function void check_result(logic signed [MEAN_W-1:0] m, logic [PERIOD_W-1:0] c);
            window_mean_t e;
            if (pending.size() == 0)
            begin
                note_failure($sformatf("result with nothing expected: mean %0d count %0d",
                                       m, c));
                return;
            end
            e = pending.pop_front();
            if (m !== e.mean || c !== e.count)
                note_failure($sformatf("mean exp %0d got %0d, count exp %0d got %0d",
                                       e.mean, m, e.count, c));
        endfunction

        function void note_failure(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("mismatch: %s", msg);
        endfunction
    endclass

    // every input known from time zero
    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       period_wen   = 1'b0;
    logic [PERIOD_W-1:0]        period_wdata = '0;
    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample       = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic signed [MEAN_W-1:0]   mean;
    logic [PERIOD_W-1:0]        samples_in_window;

    window_scoreboard board;

    // idling knobs, changed by the main sequence just after a rising edge
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    simple_moving_average dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .period_wen        (period_wen),
        .period_wdata      (period_wdata),
        .sample_valid      (sample_valid),
        .sample_stall      (sample_stall),
        .sample            (sample),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .mean              (mean),
        .samples_in_window (samples_in_window)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: check at the rising edge, choose the next stall at the falling edge;
    // a long hold-off counts down here while the sender keeps offering requests
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                board.check_result(mean, samples_in_window);
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // offer one sample request, with random idle cycles first; entered and left
    // at a falling edge so that valid gets one assignment per edge
    task automatic drive_sample(input logic signed [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            sample       <= SAMPLE_W'($urandom);
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        board.note_sample(value);
        @(negedge clk);
    endtask

    // period writes only once the block has delivered everything outstanding
    task automatic write_period(input logic [PERIOD_W-1:0] p);
        sample_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        period_wen   <= 1'b1;
        period_wdata <= p;
        @(negedge clk);
        period_wen <= 1'b0;
        board.set_period(p);
    endtask

    // knobs move just after a rising edge, away from the falling-edge drivers
    task automatic set_idling(input int send_pct, input int recv_pct, input int hold);
        @(posedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        hold_left      = hold;
        @(negedge clk);
    endtask

    // extremes, all-zero, all-one, alternating bits and small values around zero;
    // the first ten run at the reset period and wrap the window
    function automatic logic signed [SAMPLE_W-1:0] directed_sample(input int i);
        case (i)
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MAX;
            2:       return SAMPLE_MIN;
            3:       return SAMPLE_MIN;
            4:       return 16'sd0;
            5:       return -16'sd1;
            6:       return 16'sd1;
            7:       return -16'sd3;
            8:       return 16'sh5555;
            9:       return 16'shaaaa;
            10:      return SAMPLE_MIN;
            11:      return SAMPLE_MAX;
            default: return -16'sd1;
        endcase
    endfunction

    // one period setting per phase: exact values, zero and values past the depth
    function automatic logic [PERIOD_W-1:0] phase_period(input int phase);
        case (phase)
            0:       return 7'd1;
            1:       return 7'd65;
            2:       return 7'd3;
            3:       return 7'd64;
            4:       return 7'd127;
            5:       return 7'd2;
            6:       return 7'd17;
            7:       return 7'd0;
            8:       return 7'd33;
            default: return PERIOD_W'($urandom_range(64, 1));
        endcase
    endfunction

    // mostly full-range values, with extremes and tiny values to exercise truncation
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return SAMPLE_W'($urandom_range(8)) - SAMPLE_W'(4);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int                         phase;
        int                         n;
        int                         streak_left;
        logic signed [SAMPLE_W-1:0] streak_value;
        logic signed [SAMPLE_W-1:0] value;

        board       = new();
        streak_left = 0;

        // reset held from time zero, released at a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed requests at the reset period, then with period zero
        for (n = 0; n < DIRECTED_ITEMS; n++)
        begin
            if (n == DIRECTED_AT_RST)
                write_period('0);
            drive_sample(directed_sample(n));
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            write_period(phase_period(phase));
            case (phase % 4)
                0:       set_idling(0, 0, 0);
                1:       set_idling(56, 0, 0);
                2:       set_idling(0, 56, LONG_HOLD);
                default: set_idling(26, 26, 0);
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // runs of one extreme fill even the widest window to its limit
                if (streak_left == 0 && $urandom_range(49) == 0)
                begin
                    streak_left  = STREAK_LEN;
                    streak_value = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
                end
                if (streak_left > 0)
                begin
                    value = streak_value;
                    streak_left--;
                end
                else
                    value = random_sample();
                drive_sample(value);
            end
        end

        // drain, then allow one more sample time for stray results
        sample_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
design/sma_pkg.sv
design/sma_div.sv
design/simple_moving_average.sv
test/simple_moving_average_tb.sv
